[sv/rpp_pkg.sv]
// Package for the raster primitive plotter: cell codes, command kinds,
// the internal operation record passed from the front end to the drawing engine.
// No dependencies.
package rpp_pkg;

    localparam int RPP_BOARD_SIZE  = 32;
    localparam int RPP_QUEUE_DEPTH = 4;

    localparam int COORD_W   = 5;
    localparam int CODE_W    = 3;
    localparam int KIND_W    = 3;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    // Cell codes held in the framebuffer.
    localparam logic [CODE_W-1:0] CODE_BLANK  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_POINT  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_EDGE   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_VERT   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_CIRCLE = 3'd4;

    // Command kinds carried on s_tuser.
    localparam logic [KIND_W-1:0] KIND_POINT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HLINE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VLINE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RECT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CIRCLE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

    // Primitive operations that the drawing engine understands.
    typedef enum logic [1:0] {
        OP_HSPAN  = 2'd0,
        OP_VSPAN  = 2'd1,
        OP_CIRCLE = 2'd2,
        OP_READ   = 2'd3
    } op_kind_t;

    // A span runs along its axis from its start coordinate to span_end.
    typedef struct packed {
        op_kind_t             kind;
        logic [CODE_W-1:0]    code;
        logic [COORD_W-1:0]   xa;
        logic [COORD_W-1:0]   ya;
        logic [COORD_W-1:0]   span_end;
        logic [COORD_W-1:0]   rad;
    } op_t;

endpackage

[sv/rpp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rpp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/rpp_front.sv]
// Front end of the plotter: takes one command item, checks its ranges and
// breaks it into primitive operations for the queue. Depends on rpp_pkg.
module rpp_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept_en,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rpp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [rpp_pkg::KIND_W-1:0]      s_tuser,
    output logic                            op_valid,
    input  logic                            op_ready,
    output rpp_pkg::op_t                    op
);
    import rpp_pkg::*;

    logic                busy_reg, busy_next;
    logic [1:0]          phase_reg, phase_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [COORD_W-1:0]  x0_reg, y0_reg, x1_reg, y1_reg, r_reg;
    logic                emit, last, advance, accept;

    assign s_tready = !busy_reg && accept_en;
    assign accept   = s_tvalid && s_tready;

    // Work out the operation for the current phase; empty ranges are skipped.
    always_comb begin
        op          = '0;
        op.kind     = OP_HSPAN;
        op.xa       = x0_reg;
        op.ya       = y0_reg;
        op.rad      = r_reg;
        op.span_end = x1_reg;
        emit        = 1'b0;
        last        = 1'b1;
        case (kind_reg)
            KIND_POINT: begin
                op.code     = CODE_POINT;
                op.span_end = x0_reg;
                emit        = 1'b1;
            end
            KIND_HLINE: begin
                op.code = CODE_EDGE;
                emit    = (x0_reg <= x1_reg);
            end
            KIND_VLINE: begin
                op.kind     = OP_VSPAN;
                op.code     = CODE_VERT;
                op.span_end = y1_reg;
                emit        = (y0_reg <= y1_reg);
            end
            KIND_RECT: begin
                op.code = CODE_EDGE;
                case (phase_reg)
                    2'd0: begin
                        emit = (x0_reg <= x1_reg);
                        last = 1'b0;
                    end
                    2'd1: begin
                        op.ya = y1_reg;
                        emit  = (x0_reg <= x1_reg);
                        last  = 1'b0;
                    end
                    2'd2: begin
                        op.kind     = OP_VSPAN;
                        op.span_end = COORD_W'(y1_reg - 5'd1);
                        emit        = (y0_reg < y1_reg);
                        last        = 1'b0;
                    end
                    default: begin
                        op.kind     = OP_VSPAN;
                        op.xa       = x1_reg;
                        op.span_end = COORD_W'(y1_reg - 5'd1);
                        emit        = (y0_reg < y1_reg);
                    end
                endcase
            end
            KIND_CIRCLE: begin
                op.kind = OP_CIRCLE;
                op.code = CODE_CIRCLE;
                emit    = 1'b1;
            end
            KIND_READ: begin
                op.kind = OP_READ;
                op.code = CODE_BLANK;
                emit    = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign op_valid = busy_reg && emit;
    assign advance  = busy_reg && (!emit || op_ready);

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (accept) begin
            busy_next  = 1'b1;
            phase_next = 2'd0;
        end else if (advance) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            x0_reg   <= s_tdata[4:0];
            y0_reg   <= s_tdata[9:5];
            x1_reg   <= s_tdata[14:10];
            y1_reg   <= s_tdata[19:15];
            r_reg    <= s_tdata[24:20];
        end
    end

endmodule

[sv/rpp_fifo.sv]
// Short operation queue between the front end and the drawing engine.
// Depends on rpp_pkg.
module rpp_fifo #(
    parameter int DEPTH = rpp_pkg::RPP_QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  rpp_pkg::op_t  push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rpp_pkg::op_t  pop_op
);
    import rpp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    op_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push_fire, pop_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not rise on push");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_fire && !push_fire) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not fall on pop");

endmodule

[sv/rpp_back.sv]
// Drawing engine of the plotter: clears the framebuffer after reset, then
// steps through queued operations one cell per cycle. Depends on rpp_pkg, rpp_ram.
module rpp_back #(
    parameter int BOARD_SIZE = rpp_pkg::RPP_BOARD_SIZE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          clearing,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  rpp_pkg::op_t                  q_op,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rpp_pkg::CODE_W-1:0]    cell_code
);
    import rpp_pkg::*;

    localparam int IDX_W  = $clog2(BOARD_SIZE);
    localparam int DEPTH  = BOARD_SIZE * BOARD_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] BS_A      = ADDR_W'(BOARD_SIZE);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_SPAN    = 6'b000100,
        ST_CIRC    = 6'b001000,
        ST_RD_ADDR = 6'b010000,
        ST_RD_DATA = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    op_t                  op_reg, op_next;
    logic [COORD_W-1:0]   pos_reg, pos_next;
    logic signed [5:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic [9:0]           r2_reg, r2_next;
    logic                 offb_reg, offb_next;
    logic                 pix_valid_reg, pix_valid_next;
    logic [IDX_W-1:0]     pix_x_reg, pix_x_next, pix_y_reg, pix_y_next;
    logic [CODE_W-1:0]    pix_code_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]    m_code_reg;

    logic signed [7:0]    cur_x, cur_y, circ_x, circ_y;
    logic [COORD_W-1:0]   span_x, span_y;
    logic                 cur_hit, in_circle, out_load;
    logic [4:0]           abs_dx, abs_dy;
    logic [9:0]           sq_dx, sq_dy;
    logic [10:0]          dist_sq;
    logic signed [5:0]    r_s;
    logic                 rd_on_board;
    logic                 ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]    ram_wr_addr, ram_rd_addr;
    logic [CODE_W-1:0]    ram_wr_data, ram_rd_data;

    function automatic logic on_board(input logic signed [7:0] c);
        return (c >= 0) && (int'(c) < BOARD_SIZE);
    endfunction

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = m_valid_reg;
    assign cell_code = m_code_reg;

    // Cell under the cursor for spans and for the circle scan.
    assign span_x = (op_reg.kind == OP_HSPAN) ? pos_reg : op_reg.xa;
    assign span_y = (op_reg.kind == OP_HSPAN) ? op_reg.ya : pos_reg;
    assign circ_x = $signed({3'b000, op_reg.xa}) + $signed({{2{dx_reg[5]}}, dx_reg});
    assign circ_y = $signed({3'b000, op_reg.ya}) + $signed({{2{dy_reg[5]}}, dy_reg});
    assign abs_dx = dx_reg[5] ? 5'(-dx_reg) : dx_reg[4:0];
    assign abs_dy = dy_reg[5] ? 5'(-dy_reg) : dy_reg[4:0];
    assign sq_dx  = 10'(abs_dx) * 10'(abs_dx);
    assign sq_dy  = 10'(abs_dy) * 10'(abs_dy);
    assign dist_sq   = {1'b0, sq_dx} + {1'b0, sq_dy};
    assign in_circle = (dist_sq <= {1'b0, r2_reg});
    assign r_s    = $signed({1'b0, op_reg.rad});
    assign rd_on_board = on_board($signed({3'b000, op_reg.xa}))
                      && on_board($signed({3'b000, op_reg.ya}));

    always_comb begin
        cur_x   = $signed({3'b000, span_x});
        cur_y   = $signed({3'b000, span_y});
        cur_hit = 1'b0;
        case (state_reg)
            ST_SPAN: begin
                cur_hit = 1'b1;
            end
            ST_CIRC: begin
                cur_x   = circ_x;
                cur_y   = circ_y;
                cur_hit = in_circle;
            end
            default: begin
                cur_hit = 1'b0;
            end
        endcase
    end

    assign pix_valid_next = cur_hit && on_board(cur_x) && on_board(cur_y);
    assign pix_x_next     = cur_x[IDX_W-1:0];
    assign pix_y_next     = cur_y[IDX_W-1:0];

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        r2_next      = r2_reg;
        offb_next    = offb_reg;
        q_pop        = 1'b0;
        ram_rd_en    = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    op_next  = q_op;
                    pos_next = (q_op.kind == OP_VSPAN) ? q_op.ya : q_op.xa;
                    dx_next  = -$signed({1'b0, q_op.rad});
                    dy_next  = -$signed({1'b0, q_op.rad});
                    r2_next  = 10'(q_op.rad) * 10'(q_op.rad);
                    case (q_op.kind)
                        OP_HSPAN, OP_VSPAN: state_next = ST_SPAN;
                        OP_CIRCLE:          state_next = ST_CIRC;
                        OP_READ:            state_next = ST_RD_ADDR;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SPAN: begin
                if (pos_reg == op_reg.span_end) begin
                    state_next = ST_IDLE;
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            ST_CIRC: begin
                if (dy_reg == r_s) begin
                    dy_next = -r_s;
                    if (dx_reg == r_s) begin
                        state_next = ST_IDLE;
                    end else begin
                        dx_next = dx_reg + 6'sd1;
                    end
                end else begin
                    dy_next = dy_reg + 6'sd1;
                end
            end
            ST_RD_ADDR: begin
                // The read waits until the last pending cell write has landed.
                if (!pix_valid_reg) begin
                    ram_rd_en  = rd_on_board;
                    offb_next  = !rd_on_board;
                    state_next = ST_RD_DATA;
                end
            end
            ST_RD_DATA: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign ram_rd_addr = ADDR_W'(op_reg.ya) * BS_A + ADDR_W'(op_reg.xa);
    assign ram_wr_en   = clearing || pix_valid_reg;
    assign ram_wr_addr = clearing ? clr_cnt_reg
                                  : ADDR_W'(pix_y_reg) * BS_A + ADDR_W'(pix_x_reg);
    assign ram_wr_data = clearing ? CODE_BLANK : pix_code_reg;

    rpp_ram #(
        .WIDTH (CODE_W),
        .DEPTH (DEPTH)
    ) u_fb (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pix_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pix_valid_reg <= pix_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        r2_reg       <= r2_next;
        offb_reg     <= offb_next;
        pix_x_reg    <= pix_x_next;
        pix_y_reg    <= pix_y_next;
        pix_code_reg <= op_reg.code;
        if (out_load) begin
            m_code_reg <= offb_reg ? CODE_BLANK : ram_rd_data;
        end
    end

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_rd_en && ram_wr_en))
        else $error("framebuffer read issued while a write is pending");

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while still held");

    a_pix_on_board: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_valid_reg |-> (int'(pix_x_reg) < BOARD_SIZE && int'(pix_y_reg) < BOARD_SIZE))
        else $error("cell write outside the board");

endmodule

[sv/raster_primitive_plotter.sv]
// Raster primitive plotter, top level: streaming command input, read results
// out. Depends on rpp_pkg, rpp_front, rpp_fifo, rpp_back, rpp_ram.
//
// The block keeps a BOARD_SIZE by BOARD_SIZE framebuffer of 3-bit cell codes
// in one RAM and draws points, horizontal and vertical lines, rectangle
// outlines and filled circles into it; a read command returns one cell.
// After reset the framebuffer is cleared by a pass over all
// BOARD_SIZE*BOARD_SIZE cells (1024 at the default size), during which s_tready
// stays low. The front end registers one command item, turns it into up to
// four primitive operations and places them in a short queue; s_tready is low
// while an item is being broken down. The drawing engine writes one cell per
// cycle through the single RAM write port; a filled circle of radius r is
// scanned over its (2r+1) by (2r+1) square, and a read waits until no cell
// write is pending. Cells off the board are skipped, and a read off the board
// returns blank. The result sits in an output register, so the engine keeps
// working through queued drawing while a read result waits on m_tready.
module raster_primitive_plotter #(
    parameter int BOARD_SIZE  = rpp_pkg::RPP_BOARD_SIZE,
    parameter int QUEUE_DEPTH = rpp_pkg::RPP_QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata from bit 0: x_start[4:0], y_start[9:5], x_end[14:10],
    // y_end[19:15], radius[24:20], zeros above
    input  logic [rpp_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: kind[2:0]
    input  logic [rpp_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0: cell_code[2:0], zeros above
    output logic [rpp_pkg::M_TDATA_W-1:0]  m_tdata
);
    import rpp_pkg::*;

    logic               clearing;
    logic               f_valid, f_ready, q_valid, q_pop;
    op_t                f_op, q_op;
    logic [CODE_W-1:0]  cell_code;

    // Items are held off until the clearing pass has finished.
    rpp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept_en (!clearing),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .op_valid  (f_valid),
        .op_ready  (f_ready),
        .op        (f_op)
    );

    rpp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_op    (f_op),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_op     (q_op)
    );

    rpp_back #(
        .BOARD_SIZE (BOARD_SIZE)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_op      (q_op),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cell_code (cell_code)
    );

    assign m_tdata = {{(M_TDATA_W - CODE_W){1'b0}}, cell_code};

endmodule
